@@ src/turn_limited_pursuit_steering_macros.svh @@
// Assertion macros for the pursuit steering block.
`ifndef TURN_LIMITED_PURSUIT_STEERING_MACROS_SVH
`define TURN_LIMITED_PURSUIT_STEERING_MACROS_SVH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TLPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("steering assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TLPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("steering assertion failed");
`endif

@@ src/tlps_pkg.sv @@
// Types, constants and the arctangent table of the pursuit steering block.
package tlps_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int ITER_N  = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
    localparam int ITER_W  = $clog2(ANGLE_TABLE_LEN);
    localparam int CW      = 36;
    localparam int PW      = 2 * CW;

    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(ITER_N - 1);
    localparam logic signed [CW-1:0] GAIN_START   = CW'(36'sh026DD3B6A);
    localparam logic signed [CW-1:0] QUARTER_TURN = CW'(36'sh040000000);
    localparam logic signed [CW-1:0] HALF_TURN    = CW'(36'sh080000000);

    typedef enum logic [2:0] {
        CFG_MOVE_SPEED = 3'd0,
        CFG_TURN_RATE  = 3'd1,
        CFG_NEAR_LIMIT = 3'd2,
        CFG_START_X    = 3'd3,
        CFG_START_Z    = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_MULX,
        ST_MULZ,
        ST_ADDZ,
        ST_DIFF,
        ST_SQX,
        ST_SQZ,
        ST_CMP,
        ST_VEC,
        ST_TURN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_z;
        logic        [15:0] delta_t;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic        [15:0] heading_out;
        logic               turned;
    } rsp_t;

    typedef struct packed {
        logic              load;
        logic              run;
        logic              vec_mode;
        logic [ITER_W-1:0] iter;
    } cordic_ctrl_t;

    function automatic logic [31:0] atan_unit(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/turn_limited_pursuit_steering.sv @@
// Top level of the turn-rate limited pursuit steering block.
// The req channel carries one tick transaction: target x/z and the time step.
// The rsp channel returns one transaction per tick: position, heading and
// the turned flag. Both channels use valid/ready handshakes.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Writing a start coordinate also loads the position at once.
// After acceptance a tick runs the sin/cos rotation pass (ST_ROT), then the
// multiply, saturate, difference, square and compare states (ST_MULX to ST_CMP)
// on one shared multiplier and, for a far target, the vectoring pass (ST_VEC)
// and the turn state (ST_TURN), then the output state (ST_OUT). req_ready
// returns once the block is back in ST_IDLE after the output state.
// The result sits in an output register; a new tick is accepted while it
// waits, but the next result holds until the receiver takes the previous one.
// Reset loads the register defaults, the position at zero and heading zero.
module turn_limited_pursuit_steering (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tlps_pkg::req_t     req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tlps_pkg::rsp_t     rsp_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = tlps_pkg::CW;
    localparam int PW = tlps_pkg::PW;

    tlps_pkg::state_t state_reg, state_next;
    logic [tlps_pkg::ITER_W-1:0] iter_reg, iter_next;

    logic [15:0] move_speed_reg, turn_rate_reg, near_limit_reg;
    logic signed [31:0] pos_x_reg, pos_z_reg;
    logic [15:0] heading_reg;
    logic signed [31:0] tx_reg, tz_reg;
    logic [23:0] step_reg;
    logic [31:0] lim_reg;
    logic [15:0] maxt_reg;
    logic flip_reg;
    logic signed [32:0] dx_reg, dz_reg;
    logic [63:0] sqx_reg;
    logic signed [PW-1:0] prod_reg;
    logic rsp_valid_reg;
    tlps_pkg::rsp_t rsp_reg;

    tlps_pkg::cordic_ctrl_t ctrl;
    logic signed [CW-1:0] cx_init, cy_init, cz_init, cx, cy, cz;
    logic signed [CW-1:0] ang, ang_f, sn, cs;
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [CW-1:0] adx, adz;
    logic signed [PW-1:0] sum_pos, prod_sh;
    logic signed [31:0] sat_val;
    logic [64:0] sq_sum;
    logic far;
    logic [15:0] b16, diffu, diff_c;
    logic signed [17:0] diff18, m18;
    logic accept_req, out_free;
    logic [31:0] mts, mtr;

    tlps_cordic u_cordic (
        .clk    (clk),
        .ctrl   (ctrl),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .x      (cx),
        .y      (cy),
        .z      (cz)
    );

    assign req_ready  = (state_reg == tlps_pkg::ST_IDLE);
    assign accept_req = req_valid && req_ready;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    always_comb
    begin
        ang   = $signed({{(CW-32){heading_reg[15]}}, heading_reg, 16'h0000});
        ang_f = ang;
        if (ang > tlps_pkg::QUARTER_TURN || ang < -tlps_pkg::QUARTER_TURN)
        begin
            ang_f = (ang > 0) ? ang - tlps_pkg::HALF_TURN : ang + tlps_pkg::HALF_TURN;
        end
        sn  = flip_reg ? -cy : cy;
        cs  = flip_reg ? -cx : cx;
        adx = dx_reg[32] ? -CW'(dx_reg) : CW'(dx_reg);
        adz = dz_reg[32] ? -CW'(dz_reg) : CW'(dz_reg);
        mts = 32'(move_speed_reg) * 32'(req_data.delta_t);
        mtr = 32'(turn_rate_reg) * 32'(req_data.delta_t);
    end

    always_comb
    begin
        case (state_reg)
            tlps_pkg::ST_MULX: begin mul_a = $signed({12'h000, step_reg}); mul_b = sn; end
            tlps_pkg::ST_MULZ: begin mul_a = $signed({12'h000, step_reg}); mul_b = cs; end
            tlps_pkg::ST_SQX:  begin mul_a = adx; mul_b = adx; end
            default:           begin mul_a = adz; mul_b = adz; end
        endcase
        prod_sh = prod_reg >>> 30;
        sum_pos = (state_reg == tlps_pkg::ST_MULZ) ? PW'(pos_x_reg) + prod_sh
                                                   : PW'(pos_z_reg) + prod_sh;
        if (sum_pos > PW'(64'sh7FFFFFFF))
            sat_val = 32'sh7FFFFFFF;
        else if (sum_pos < -PW'(64'sh80000000))
            sat_val = -32'sh80000000;
        else
            sat_val = sum_pos[31:0];
        sq_sum = {1'b0, sqx_reg} + {1'b0, prod_reg[63:0]};
        far    = sq_sum > {33'h0, lim_reg};
        b16    = 16'((cz[31:0] + 32'h00008000) >> 16);
        diffu  = b16 - heading_reg;
        diff18 = 18'(signed'(diffu));
        m18    = $signed({2'b00, maxt_reg});
        if (diff18 > m18)
            diff_c = maxt_reg;
        else if (diff18 < -m18)
            diff_c = -maxt_reg;
        else
            diff_c = diffu;
    end

    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        ctrl.load     = 1'b0;
        ctrl.run      = 1'b0;
        ctrl.vec_mode = (state_reg == tlps_pkg::ST_VEC) || (state_reg == tlps_pkg::ST_CMP);
        ctrl.iter     = iter_reg;
        cx_init       = tlps_pkg::GAIN_START;
        cy_init       = '0;
        cz_init       = ang_f;
        unique case (state_reg)
            tlps_pkg::ST_IDLE:
            begin
                if (accept_req)
                begin
                    ctrl.load  = 1'b1;
                    iter_next  = '0;
                    state_next = tlps_pkg::ST_ROT;
                end
            end
            tlps_pkg::ST_ROT, tlps_pkg::ST_VEC:
            begin
                ctrl.run  = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == tlps_pkg::ITER_LAST)
                    state_next = (state_reg == tlps_pkg::ST_ROT) ? tlps_pkg::ST_MULX
                                                                 : tlps_pkg::ST_TURN;
            end
            tlps_pkg::ST_MULX: state_next = tlps_pkg::ST_MULZ;
            tlps_pkg::ST_MULZ: state_next = tlps_pkg::ST_ADDZ;
            tlps_pkg::ST_ADDZ: state_next = tlps_pkg::ST_DIFF;
            tlps_pkg::ST_DIFF: state_next = tlps_pkg::ST_SQX;
            tlps_pkg::ST_SQX:  state_next = tlps_pkg::ST_SQZ;
            tlps_pkg::ST_SQZ:  state_next = tlps_pkg::ST_CMP;
            tlps_pkg::ST_CMP:
            begin
                if (dz_reg[32])
                begin
                    cx_init = -CW'(dz_reg);
                    cy_init = -CW'(dx_reg);
                    cz_init = tlps_pkg::HALF_TURN;
                end
                else
                begin
                    cx_init = CW'(dz_reg);
                    cy_init = CW'(dx_reg);
                    cz_init = '0;
                end
                if (far)
                begin
                    ctrl.load  = 1'b1;
                    iter_next  = '0;
                    state_next = tlps_pkg::ST_VEC;
                end
                else
                begin
                    state_next = tlps_pkg::ST_OUT;
                end
            end
            tlps_pkg::ST_TURN: state_next = tlps_pkg::ST_OUT;
            tlps_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = tlps_pkg::ST_IDLE;
            end
            default: state_next = tlps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlps_pkg::ST_IDLE;
            iter_reg       <= '0;
            move_speed_reg <= 16'd1280;
            turn_rate_reg  <= 16'd10923;
            near_limit_reg <= 16'd655;
            pos_x_reg      <= '0;
            pos_z_reg      <= '0;
            heading_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg.turned <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tlps_pkg::CFG_MOVE_SPEED: move_speed_reg <= cfg_data[15:0];
                    tlps_pkg::CFG_TURN_RATE:  turn_rate_reg  <= cfg_data[15:0];
                    tlps_pkg::CFG_NEAR_LIMIT: near_limit_reg <= cfg_data[15:0];
                    tlps_pkg::CFG_START_X:    pos_x_reg      <= $signed(cfg_data);
                    tlps_pkg::CFG_START_Z:    pos_z_reg      <= $signed(cfg_data);
                    default: ;
                endcase
            end
            if (state_reg == tlps_pkg::ST_MULZ)
                pos_x_reg <= sat_val;
            if (state_reg == tlps_pkg::ST_ADDZ)
                pos_z_reg <= sat_val;
            if (state_reg == tlps_pkg::ST_TURN)
                heading_reg <= heading_reg + diff_c;
            if (state_reg == tlps_pkg::ST_OUT && out_free)
            begin
                rsp_valid_reg       <= 1'b1;
                rsp_reg.pos_x       <= pos_x_reg;
                rsp_reg.pos_z       <= pos_z_reg;
                rsp_reg.heading_out <= heading_reg;
                rsp_reg.turned      <= far;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_req)
        begin
            tx_reg   <= req_data.target_x;
            tz_reg   <= req_data.target_z;
            step_reg <= mts[31:8];
            maxt_reg <= mtr[31:16];
            lim_reg  <= 32'(near_limit_reg) * 32'(near_limit_reg);
            flip_reg <= (ang > tlps_pkg::QUARTER_TURN) || (ang < -tlps_pkg::QUARTER_TURN);
        end
        if (state_reg == tlps_pkg::ST_MULX || state_reg == tlps_pkg::ST_MULZ
            || state_reg == tlps_pkg::ST_SQX || state_reg == tlps_pkg::ST_SQZ)
            prod_reg <= mul_a * mul_b;
        if (state_reg == tlps_pkg::ST_DIFF)
        begin
            dx_reg <= 33'(tx_reg) - 33'(pos_x_reg);
            dz_reg <= 33'(tz_reg) - 33'(pos_z_reg);
        end
        if (state_reg == tlps_pkg::ST_SQZ)
            sqx_reg <= prod_reg[63:0];
    end

endmodule

@@ src/tlps_cordic.sv @@
// Shared CORDIC micro-rotation unit for rotation and vectoring passes.
module tlps_cordic (
    input  logic                             clk,
    input  tlps_pkg::cordic_ctrl_t           ctrl,
    input  logic signed [tlps_pkg::CW-1:0]   x_init,
    input  logic signed [tlps_pkg::CW-1:0]   y_init,
    input  logic signed [tlps_pkg::CW-1:0]   z_init,
    output logic signed [tlps_pkg::CW-1:0]   x,
    output logic signed [tlps_pkg::CW-1:0]   y,
    output logic signed [tlps_pkg::CW-1:0]   z
);

    logic signed [tlps_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic signed [tlps_pkg::CW-1:0] x_next, y_next, z_next;
    logic signed [tlps_pkg::CW-1:0] xs, ys, ang;
    logic                           dir_pos;

    always_comb
    begin
        xs      = x_reg >>> ctrl.iter;
        ys      = y_reg >>> ctrl.iter;
        ang     = $signed({{(tlps_pkg::CW-32){1'b0}}, tlps_pkg::atan_unit(ctrl.iter)});
        dir_pos = ctrl.vec_mode ? y_reg[tlps_pkg::CW-1] : ~z_reg[tlps_pkg::CW-1];
        if (dir_pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - ang;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (ctrl.run)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

endmodule

@@ src/tlps_checker.sv @@
// Port-level checker for the pursuit steering block, bound to the top level.
`include "turn_limited_pursuit_steering_macros.svh"
module tlps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input tlps_pkg::rsp_t rsp_data,
    input logic           rsp_valid,
    input logic           rsp_ready
);

    `TLPS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `TLPS_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
    `TLPS_ASSERT_NXT(a_no_rsp_next, req_valid && req_ready && !rsp_valid, !rsp_valid)

endmodule

bind turn_limited_pursuit_steering tlps_checker u_tlps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
);
